// File: rtl/core/dtmf_pkg.sv
// Shared types, constants and the quarter-wave sine function of the DTMF generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dtmf_pkg;

   localparam int unsigned PHASE_BITS_DEF     = 32;
   localparam int unsigned SINE_ADDR_BITS_DEF = 10;
   localparam int unsigned SAMPLE_RATE_HZ_DEF = 8000;

   localparam int unsigned MAG_BITS    = 18;
   localparam int unsigned SAMPLE_BITS = 21;
   localparam int unsigned TICK_BITS   = 16;
   localparam int unsigned COUNT_BITS  = 4;
   localparam int unsigned INDEX_BITS  = 2;
   localparam int unsigned CODE_BITS   = 4;

   localparam logic [MAG_BITS-1:0]   FULL_SCALE  = 18'h3FFFF;
   localparam logic [COUNT_BITS-1:0] PERIOD_WRAP = 4'd12;
   localparam logic [63:0]           HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0]           ONE_Q30     = 64'd1 << 30;

   localparam logic [INDEX_BITS-1:0] COLUMN_MAX = 2'd2;
   localparam logic [INDEX_BITS-1:0] ROW_MAX    = 2'd3;

   localparam int unsigned COLUMN_HZ [4] = '{1209, 1336, 1477, 1209};
   localparam int unsigned ROW_HZ    [4] = '{697, 770, 852, 941};

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_TICK   = 1'b0,
      OP_BUTTON = 1'b1
   } op_type;

   localparam logic [CODE_BITS-1:0] BTN_COLUMN_DOWN = 4'd1;
   localparam logic [CODE_BITS-1:0] BTN_COLUMN_UP   = 4'd2;
   localparam logic [CODE_BITS-1:0] BTN_ROW_DOWN    = 4'd4;
   localparam logic [CODE_BITS-1:0] BTN_ROW_UP      = 4'd8;

   typedef struct packed {
      logic [INDEX_BITS-1:0] column;
      logic [INDEX_BITS-1:0] row;
   } tick_item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic [COUNT_BITS-1:0]         period_count;
      logic [INDEX_BITS-1:0]         column_now;
      logic [INDEX_BITS-1:0]         row_now;
   } rsp_item_type;

   typedef struct packed {
      logic                 empty;
      logic                 full;
      logic [QCNT_BITS-1:0] count;
   } queue_status_type;

   // Quarter-wave sine magnitude in full-scale units, k in 0..2^shift.
   function automatic logic [MAG_BITS-1:0] quarter_sine(input logic [63:0] k,
                                                        input int unsigned shift);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] m;
      x  = (k * HALF_PI_Q30) >> shift;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      m  = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      return m[MAG_BITS-1:0];
   endfunction

endpackage

// File: rtl/core/dtmf_fifo.sv
// Small register queue used between front and back and on the result side.
// Depends on dtmf_pkg for depth and status type.
`timescale 1ns / 1ps

module dtmf_fifo #(
   parameter int unsigned WIDTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   output logic [WIDTH-1:0]           rd_data,
   output dtmf_pkg::queue_status_type status
);
   import dtmf_pkg::*;

   logic [WIDTH-1:0]     mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_wr;
   logic                 do_rd;

   assign do_wr = wr_en && (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign do_rd = rd_en && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign status.count = count_ff;

endmodule

// File: rtl/core/dtmf_front.sv
// Front part: accepts items, applies keypad events to the column and row indexes
// and queues sample ticks with the indexes in force. Depends on dtmf_pkg.
`timescale 1ns / 1ps

module dtmf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic                       req_op,
   input  logic [3:0]                 req_button_code,
   input  dtmf_pkg::queue_status_type queue_status,
   output logic                       queue_wr_en,
   output dtmf_pkg::tick_item_type    queue_wr_item
);
   import dtmf_pkg::*;

   logic [INDEX_BITS-1:0] column_ff, column_in;
   logic [INDEX_BITS-1:0] row_ff, row_in;
   logic                  accept;
   op_type                op;

   assign full   = queue_status.full;
   assign accept = push && !queue_status.full;
   assign op     = op_type'(req_op);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept && (op == OP_BUTTON)) begin
         unique case (req_button_code)
            BTN_COLUMN_DOWN: if (column_ff != '0) column_in = column_ff - 1'b1;
            BTN_COLUMN_UP:   if (column_ff != COLUMN_MAX) column_in = column_ff + 1'b1;
            BTN_ROW_DOWN:    if (row_ff != '0) row_in = row_ff - 1'b1;
            BTN_ROW_UP:      if (row_ff != ROW_MAX) row_in = row_ff + 1'b1;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   assign queue_wr_en          = accept && (op == OP_TICK);
   assign queue_wr_item.column = column_ff;
   assign queue_wr_item.row    = row_ff;

endmodule

// File: rtl/core/dtmf_back.sv
// Back part: advances the two phase accumulators, runs the period counter,
// looks up both sines and forms the sample. Depends on dtmf_pkg.
`timescale 1ns / 1ps

module dtmf_back #(
   parameter int unsigned PHASE_BITS     = dtmf_pkg::PHASE_BITS_DEF,
   parameter int unsigned SINE_ADDR_BITS = dtmf_pkg::SINE_ADDR_BITS_DEF,
   parameter int unsigned SAMPLE_RATE_HZ = dtmf_pkg::SAMPLE_RATE_HZ_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [15:0]                csr_wr_data,
   input  dtmf_pkg::queue_status_type in_status,
   input  dtmf_pkg::tick_item_type    in_item,
   output logic                       in_rd_en,
   input  dtmf_pkg::queue_status_type out_status,
   output logic                       out_wr_en,
   output dtmf_pkg::rsp_item_type     out_item
);
   import dtmf_pkg::*;

   localparam int unsigned QW      = SINE_ADDR_BITS - 2;
   localparam int unsigned QUARTER = 1 << QW;
   localparam logic [MAG_BITS-1:0] MAG_AT_QUARTER = quarter_sine(64'(QUARTER), QW);

   logic [PHASE_BITS-1:0] column_tw [4];
   logic [PHASE_BITS-1:0] row_tw    [4];
   logic [MAG_BITS-1:0]   sine_lut  [QUARTER];

   for (genvar i = 0; i < 4; i++) begin : g_tw
      localparam logic [63:0] COL_WORD =
         ((64'(COLUMN_HZ[i]) << PHASE_BITS) + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ);
      localparam logic [63:0] ROW_WORD =
         ((64'(ROW_HZ[i]) << PHASE_BITS) + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ);
      assign column_tw[i] = COL_WORD[PHASE_BITS-1:0];
      assign row_tw[i]    = ROW_WORD[PHASE_BITS-1:0];
   end

   for (genvar i = 0; i < QUARTER; i++) begin : g_lut
      assign sine_lut[i] = quarter_sine(64'(i), QW);
   end

   logic [TICK_BITS-1:0]      period_ff;
   logic [TICK_BITS-1:0]      tick_ff, tick_in;
   logic [COUNT_BITS-1:0]     seconds_ff, seconds_in;
   logic [PHASE_BITS-1:0]     phase_ff [2];
   logic [PHASE_BITS-1:0]     phase_in [2];
   logic [PHASE_BITS-1:0]     tw_sel   [2];
   logic [SINE_ADDR_BITS-1:0] addr_ff  [2];
   logic                      valid_ff;
   logic [COUNT_BITS-1:0]     seconds_out_ff;
   logic [INDEX_BITS-1:0]     column_out_ff;
   logic [INDEX_BITS-1:0]     row_out_ff;
   logic [QCNT_BITS:0]        pending;
   logic                      issue;
   logic signed [SAMPLE_BITS-1:0] sine_val [2];

   assign pending  = {1'b0, out_status.count} + (QCNT_BITS + 1)'(valid_ff);
   assign issue    = !in_status.empty && (pending < (QCNT_BITS + 1)'(QUEUE_DEPTH));
   assign in_rd_en = issue;

   assign tw_sel[0] = column_tw[in_item.column];
   assign tw_sel[1] = row_tw[in_item.row];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         phase_in[l] = phase_ff[l] + tw_sel[l];
      end
      tick_in    = tick_ff + 1'b1;
      seconds_in = seconds_ff;
      if (tick_in == period_ff) begin
         tick_in    = '0;
         seconds_in = (seconds_ff == PERIOD_WRAP) ? COUNT_BITS'(1) : seconds_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= TICK_BITS'(SAMPLE_RATE_HZ);
         tick_ff     <= '0;
         seconds_ff  <= '0;
         phase_ff[0] <= '0;
         phase_ff[1] <= '0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (issue) begin
            tick_ff     <= tick_in;
            seconds_ff  <= seconds_in;
            phase_ff[0] <= phase_in[0];
            phase_ff[1] <= phase_in[1];
         end
         valid_ff <= issue;
      end
   end

   // Hold the stage payload for the lookup.
   always_ff @(posedge clock) begin
      if (issue) begin
         addr_ff[0]     <= phase_in[0][PHASE_BITS-1 -: SINE_ADDR_BITS];
         addr_ff[1]     <= phase_in[1][PHASE_BITS-1 -: SINE_ADDR_BITS];
         seconds_out_ff <= seconds_in;
         column_out_ff  <= in_item.column;
         row_out_ff     <= in_item.row;
      end
   end

   always_comb begin
      logic [1:0]          quad;
      logic [QW-1:0]       k;
      logic [QW-1:0]       k_mirror;
      logic [MAG_BITS-1:0] mag;
      for (int l = 0; l < 2; l++) begin
         quad     = addr_ff[l][SINE_ADDR_BITS-1 -: 2];
         k        = addr_ff[l][QW-1:0];
         k_mirror = QW'(0) - k;
         if (!quad[0]) begin
            mag = sine_lut[k];
         end else if (k == '0) begin
            mag = MAG_AT_QUARTER;
         end else begin
            mag = sine_lut[k_mirror];
         end
         sine_val[l] = quad[1] ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
      end
   end

   assign out_wr_en             = valid_ff;
   assign out_item.sample_value = sine_val[0] + sine_val[1]
                                  + $signed({3'b000, FULL_SCALE});
   assign out_item.period_count = seconds_out_ff;
   assign out_item.column_now   = column_out_ff;
   assign out_item.row_now      = row_out_ff;

endmodule

// File: rtl/core/dtmf_dual_tone_generator_top.sv
// Top level of the DTMF dual-tone generator: front, tick queue, back, result queue.
// Depends on dtmf_pkg, dtmf_fifo, dtmf_front and dtmf_back.
//
// Takes one item per clock while full is low: a sample tick (req_op 0) or a keypad
// event (req_op 1, codes 1/2/4/8 step the column or row index, anything else is
// ignored). Each tick yields one result, a keypad event none. A tick's result
// passes through the four-entry tick queue and the back part's lookup register into
// a four-entry result queue, which feeds the rsp_ ports. Sustained rate is one item
// per cycle while pop keeps up; full rises when the tick queue fills. csr_wr_data
// sets the ticks per period count step (reset SAMPLE_RATE_HZ).
`timescale 1ns / 1ps

module dtmf_dual_tone_generator_top #(
   parameter int unsigned PHASE_BITS     = dtmf_pkg::PHASE_BITS_DEF,
   parameter int unsigned SINE_ADDR_BITS = dtmf_pkg::SINE_ADDR_BITS_DEF,
   parameter int unsigned SAMPLE_RATE_HZ = dtmf_pkg::SAMPLE_RATE_HZ_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_op,
   input  logic [3:0]         req_button_code,
   output logic               empty,
   input  logic               pop,
   output logic signed [20:0] rsp_sample_value,
   output logic [3:0]         rsp_period_count,
   output logic [1:0]         rsp_column_now,
   output logic [1:0]         rsp_row_now,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);
   import dtmf_pkg::*;

   queue_status_type tick_status;
   queue_status_type rsp_status;
   tick_item_type    tick_wr_item;
   tick_item_type    tick_rd_item;
   rsp_item_type     rsp_wr_item;
   rsp_item_type     rsp_rd_item;
   logic             tick_wr_en;
   logic             tick_rd_en;
   logic             rsp_wr_en;
   logic [$bits(tick_item_type)-1:0] tick_rd_data;
   logic [$bits(rsp_item_type)-1:0]  rsp_rd_data;

   dtmf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (req_op),
      .req_button_code (req_button_code),
      .queue_status    (tick_status),
      .queue_wr_en     (tick_wr_en),
      .queue_wr_item   (tick_wr_item)
   );

   dtmf_fifo #(
      .WIDTH ($bits(tick_item_type))
   ) u_tick_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tick_wr_en),
      .wr_data (tick_wr_item),
      .rd_en   (tick_rd_en),
      .rd_data (tick_rd_data),
      .status  (tick_status)
   );

   assign tick_rd_item = tick_item_type'(tick_rd_data);

   dtmf_back #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_status   (tick_status),
      .in_item     (tick_rd_item),
      .in_rd_en    (tick_rd_en),
      .out_status  (rsp_status),
      .out_wr_en   (rsp_wr_en),
      .out_item    (rsp_wr_item)
   );

   dtmf_fifo #(
      .WIDTH ($bits(rsp_item_type))
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_wr_en),
      .wr_data (rsp_wr_item),
      .rd_en   (pop),
      .rd_data (rsp_rd_data),
      .status  (rsp_status)
   );

   assign rsp_rd_item      = rsp_item_type'(rsp_rd_data);
   assign empty            = rsp_status.empty;
   assign rsp_sample_value = rsp_rd_item.sample_value;
   assign rsp_period_count = rsp_rd_item.period_count;
   assign rsp_column_now   = rsp_rd_item.column_now;
   assign rsp_row_now      = rsp_rd_item.row_now;

endmodule

// File: test/tb.sv
// Self-checking bench for dtmf_dual_tone_generator_top: random ticks and keypad items,
// samples predicted in a scoreboard class. Depends on dtmf_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import dtmf_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned SETTLE       = 8;
   localparam int unsigned RANDOM_ITEMS = 205;
   localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
   localparam longint unsigned HALF_PI  = 64'd1686629713;
   localparam int unsigned SERIES_DIV [6] = '{156, 110, 72, 42, 20, 6};
   localparam int unsigned COL_TONE_HZ [3] = '{1209, 1336, 1477};
   localparam int unsigned ROW_TONE_HZ [4] = '{697, 770, 852, 941};
   localparam logic [15:0] PERIOD_SETTINGS [6] = '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd4,
                                                  16'd2};

   class dtmf_tone_checker;
      rsp_item_type samples_due[$];
      logic [31:0] col_acc;
      logic [31:0] row_acc;
      logic [1:0]  col_sel;
      logic [1:0]  row_sel;
      logic [15:0] ticks_seen;
      logic [15:0] ticks_per_step;
      logic [3:0]  second_no;
      int          errors;

      function new();
         col_acc = 0;
         row_acc = 0;
         col_sel = 0;
         row_sel = 0;
         ticks_seen = 0;
         second_no = 0;
         errors = 0;
         ticks_per_step = 16'd8000;
      endfunction

      function void set_step(logic [15:0] value);
         ticks_per_step = value;
      endfunction

      function int pending();
         return samples_due.size();
      endfunction

      function logic [31:0] phase_step(int unsigned hz);
         longint unsigned num;
         num = 64'(hz);
         num = (num << 32) + 64'd4000;
         return 32'(num / 64'd8000);
      endfunction

      function longint unsigned quarter_mag(longint unsigned k);
         longint unsigned angle;
         longint unsigned sq;
         longint unsigned term;
         longint unsigned prod;
         angle = (k * HALF_PI) / 64'd256;
         sq = (angle * angle) >> 30;
         term = UNIT_Q30;
         for (int i = 0; i < 6; i++)
            term = UNIT_Q30 - (((sq * term) >> 30) / longint'(SERIES_DIV[i]));
         prod = (angle * term) >> 30;
         return (prod * 64'd262143 + (64'd1 << 29)) >> 30;
      endfunction

      function int wave_value(logic [31:0] acc);
         longint unsigned k;
         int mag;
         k = 64'(acc[29:22]);
         if (acc[30]) k = 64'd256 - k;
         mag = int'(quarter_mag(k));
         return acc[31] ? -mag : mag;
      endfunction

      function void note_item(op_type op, logic [3:0] code);
         rsp_item_type want;
         int total;
         if (op == OP_BUTTON) begin
            case (code)
               BTN_COLUMN_DOWN: begin
                  if (col_sel > 0) col_sel = col_sel - 1'b1;
               end
               BTN_COLUMN_UP: begin
                  if (col_sel < 2) col_sel = col_sel + 1'b1;
               end
               BTN_ROW_DOWN: begin
                  if (row_sel > 0) row_sel = row_sel - 1'b1;
               end
               BTN_ROW_UP: begin
                  if (row_sel < 3) row_sel = row_sel + 1'b1;
               end
               default: ;
            endcase
            return;
         end
         col_acc = col_acc + phase_step(COL_TONE_HZ[col_sel]);
         row_acc = row_acc + phase_step(ROW_TONE_HZ[row_sel]);
         total = wave_value(col_acc) + wave_value(row_acc) + 262143;
         ticks_seen = ticks_seen + 16'd1;
         if (ticks_seen == ticks_per_step) begin
            second_no = (second_no % 4'd12) + 4'd1;
            ticks_seen = 0;
         end
         want.sample_value = total[20:0];
         want.period_count = second_no;
         want.column_now = col_sel;
         want.row_now = row_sel;
         samples_due.push_back(want);
      endfunction

      function void check_sample(rsp_item_type got);
         rsp_item_type want;
         if (samples_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected sample %0d count %0d col %0d row %0d",
                        got.sample_value, got.period_count, got.column_now, got.row_now);
            return;
         end
         want = samples_due.pop_front();
         if (got.sample_value != want.sample_value || got.period_count != want.period_count ||
             got.column_now != want.column_now || got.row_now != want.row_now) begin
            errors++;
            if (errors <= 10)
               $display("sample mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        want.sample_value, want.period_count, want.column_now, want.row_now,
                        got.sample_value, got.period_count, got.column_now, got.row_now);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               push;
   logic               full;
   logic               req_op;
   logic [3:0]         req_button_code;
   logic               empty;
   logic               pop;
   logic signed [20:0] rsp_sample_value;
   logic [3:0]         rsp_period_count;
   logic [1:0]         rsp_column_now;
   logic [1:0]         rsp_row_now;
   logic               csr_wr_en;
   logic [15:0]        csr_wr_data;

   dtmf_tone_checker chk;
   bit               send_quiet = 0;
   bit               pop_quiet = 0;
   int unsigned      idle_cycles = 0;

   dtmf_dual_tone_generator_top dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (req_op),
      .req_button_code (req_button_code),
      .empty           (empty),
      .pop             (pop),
      .rsp_sample_value(rsp_sample_value),
      .rsp_period_count(rsp_period_count),
      .rsp_column_now  (rsp_column_now),
      .rsp_row_now     (rsp_row_now),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) chk.note_item(op_type'(req_op), req_button_code);
         if (pop && !empty)
            chk.check_sample('{rsp_sample_value, rsp_period_count, rsp_column_now,
                               rsp_row_now});
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic int draw_gap();
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      return send_quiet ? 0 : int'($urandom_range(0, 5));
   endfunction

   task automatic send_item(op_type op, logic [3:0] code, int gap);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_op <= op;
      req_button_code <= code;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic drain(int settle);
      push <= 1'b0;
      do @(posedge clock); while (chk.pending() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_period(logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      chk.set_step(value);
   endtask

   task automatic send_random(int count);
      logic [3:0] code;
      repeat (count) begin
         if ($urandom_range(0, 199) == 0) drain(0);
         if ($urandom_range(0, 9) < 7) begin
            send_item(OP_TICK, 4'($urandom_range(0, 15)), draw_gap());
         end else begin
            if ($urandom_range(0, 4) < 3) code = 4'(1 << $urandom_range(0, 3));
            else code = 4'($urandom_range(0, 15));
            send_item(OP_BUTTON, code, draw_gap());
         end
      end
   endtask

   initial begin
      int stall;
      pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) pop_quiet = !pop_quiet;
         stall = pop_quiet ? 0 : int'($urandom_range(0, 5));
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
      end
   end

   initial begin
      chk = new();
      reset <= 1'b1;
      push <= 1'b0;
      req_op <= OP_TICK;
      req_button_code <= 4'd0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 16'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_TICK, 4'd0, 0);
      send_item(OP_BUTTON, BTN_COLUMN_DOWN, draw_gap());
      send_item(OP_BUTTON, BTN_ROW_DOWN, draw_gap());
      send_item(OP_TICK, 4'd0, draw_gap());
      repeat (3) send_item(OP_BUTTON, BTN_COLUMN_UP, draw_gap());
      send_item(OP_TICK, 4'd0, draw_gap());
      repeat (4) send_item(OP_BUTTON, BTN_ROW_UP, draw_gap());
      send_item(OP_TICK, 4'd0, draw_gap());
      send_item(OP_BUTTON, 4'd0, draw_gap());
      send_item(OP_BUTTON, 4'd15, draw_gap());
      send_item(OP_BUTTON, BTN_COLUMN_DOWN | BTN_COLUMN_UP, draw_gap());
      send_item(OP_BUTTON, BTN_ROW_DOWN | BTN_ROW_UP, draw_gap());
      send_item(OP_BUTTON, BTN_COLUMN_DOWN | BTN_ROW_DOWN, draw_gap());
      send_item(OP_TICK, 4'd15, draw_gap());
      send_item(OP_BUTTON, BTN_COLUMN_DOWN, draw_gap());
      send_item(OP_BUTTON, BTN_ROW_DOWN, draw_gap());
      send_item(OP_TICK, 4'd0, draw_gap());
      send_random(RANDOM_ITEMS);

      foreach (PERIOD_SETTINGS[i]) begin
         drain(SETTLE);
         write_period(PERIOD_SETTINGS[i]);
         send_random(RANDOM_ITEMS);
      end

      drain(SETTLE);
      if (chk.errors == 0 && chk.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

// File: files.f
rtl/core/dtmf_pkg.sv
rtl/core/dtmf_fifo.sv
rtl/core/dtmf_front.sv
rtl/core/dtmf_back.sv
rtl/core/dtmf_dual_tone_generator_top.sv
test/tb.sv
